// File: sv/smrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smrr_pkg;

    // Ring buffer geometry
    localparam int STORE_DEPTH = 5000;
    localparam int PTR_W       = $clog2(STORE_DEPTH);

    // Field widths
    localparam int ADC_W   = 12;
    localparam int DBH_W   = 13;
    localparam int WIDTH_W = 11;
    localparam int PAIR_W  = 2 * WIDTH_W;
    localparam int CFG_W   = DBH_W;

    // Pulse width constants, in us
    localparam logic [WIDTH_W-1:0] WIDTH_BASE_LOW = WIDTH_W'(1000);
    localparam logic [WIDTH_W-1:0] WIDTH_NEUTRAL  = WIDTH_W'(1500);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX      = WIDTH_W'(2000);

    // Slope: 500 us over 1947 (lower half) or 1948 (upper half) counts.
    // floor(n*500/D) == (n*RECIP) >> RECIP_SHIFT exactly for n < 2^12,
    // RECIP = ceil(500*2^RECIP_SHIFT / D).
    localparam longint SLOPE       = 500;
    localparam longint LOWER_DIV   = 1947;
    localparam longint UPPER_DIV   = 1948;
    localparam int     RECIP_SHIFT = 24;
    localparam int     RECIP_W     = 23;
    localparam int     PROD_W      = ADC_W + RECIP_W;
    localparam logic [RECIP_W-1:0] LOWER_RECIP =
        RECIP_W'((SLOPE * (64'd1 << RECIP_SHIFT) + LOWER_DIV - 1) / LOWER_DIV);
    localparam logic [RECIP_W-1:0] UPPER_RECIP =
        RECIP_W'((SLOPE * (64'd1 << RECIP_SHIFT) + UPPER_DIV - 1) / UPPER_DIV);

    // Output buffer
    localparam int OUT_DEPTH = 8;
    localparam int OUT_IDX_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Register indexes
    localparam logic CFG_DEADBAND_LOW  = 1'b0;
    localparam logic CFG_DEADBAND_HIGH = 1'b1;

    typedef enum logic [1:0] {
        CMD_AXIS1  = 2'd0,
        CMD_AXIS2  = 2'd1,
        CMD_BUTTON = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        RANGE_DEAD = 2'd0,
        RANGE_LOW  = 2'd1,
        RANGE_HIGH = 2'd2
    } range_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] servo1_width;
        logic [WIDTH_W-1:0] servo2_width;
        logic               playing;
    } result_t;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

`default_nettype wire

// File: sv/smrr_map.sv
`timescale 1ns / 1ps
`default_nettype none

// ADC sample to pulse width, two register stages; width is driven
// combinationally from the second register stage.
module smrr_map (
    input  wire logic                          clk,
    input  wire logic [smrr_pkg::ADC_W-1:0]    adc_value,
    input  wire logic [smrr_pkg::ADC_W-1:0]    deadband_low,
    input  wire logic [smrr_pkg::DBH_W-1:0]    deadband_high,
    output logic      [smrr_pkg::WIDTH_W-1:0]  width
);
    import smrr_pkg::*;

    logic [ADC_W-1:0]   n_reg, n_next;
    range_t             rng1_reg, rng1_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    range_t             rng2_reg;

    logic               below;
    logic               at_high;
    logic [DBH_W-1:0]   adc_ext;
    logic [DBH_W-1:0]   diff;
    logic [RECIP_W-1:0] recip;
    logic [WIDTH_W-1:0] quot;
    logic [WIDTH_W-1:0] base;
    logic [WIDTH_W:0]   sum;

    // Stage 1: range select
    always_comb
    begin
        adc_ext = {1'b0, adc_value};
        diff    = adc_ext - deadband_high;
        below   = adc_value < deadband_low;
        at_high = adc_ext >= deadband_high;
        if (!below && !at_high)
        begin
            rng1_next = RANGE_DEAD;
            n_next    = '0;
        end
        else if (below)
        begin
            rng1_next = RANGE_LOW;
            n_next    = adc_value;
        end
        else
        begin
            rng1_next = RANGE_HIGH;
            n_next    = diff[ADC_W-1:0];
        end
    end

    // Stage 2: reciprocal multiply
    always_comb
    begin
        recip     = (rng1_reg == RANGE_LOW) ? LOWER_RECIP : UPPER_RECIP;
        prod_next = PROD_W'(n_reg) * PROD_W'(recip);
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        rng1_reg <= rng1_next;
        prod_reg <= prod_next;
        rng2_reg <= rng1_reg;
    end

    // Offset and cap
    always_comb
    begin
        quot = prod_reg[RECIP_SHIFT +: WIDTH_W];
        base = (rng2_reg == RANGE_LOW) ? WIDTH_BASE_LOW : WIDTH_NEUTRAL;
        sum  = {1'b0, base} + {1'b0, quot};
        if (rng2_reg == RANGE_DEAD)
            width = WIDTH_NEUTRAL;
        else if (sum > {1'b0, WIDTH_MAX})
            width = WIDTH_MAX;
        else
            width = sum[WIDTH_W-1:0];
    end

endmodule

`default_nettype wire

// File: sv/smrr_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

// Small result queue; the credit count upstream keeps it from overflowing.
module smrr_out_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire smrr_pkg::result_t push_data,
    input  wire logic              pop,
    output logic                   not_empty,
    output smrr_pkg::result_t      head_data
);
    import smrr_pkg::*;

    result_t                entry_reg [OUT_DEPTH];
    logic [OUT_IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [OUT_IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [OUT_CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_idx_next = push ? wr_idx_reg + 1'b1 : wr_idx_reg;
        rd_idx_next = pop  ? rd_idx_reg + 1'b1 : rd_idx_reg;
        count_next  = count_reg + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_idx_reg] <= push_data;
    end

    assign not_empty = count_reg != '0;
    assign head_data = entry_reg[rd_idx_reg];

endmodule

`default_nettype wire

// File: sv/servo_motion_record_replay.sv
`timescale 1ns / 1ps
`default_nettype none

// Servo motion record and replay.
//
// Input channel (in_valid/in_ready): one beat carries cmd and adc_value.
// cmd selects an axis-1 or axis-2 joystick sample, a button press or a
// sample tick. Every input beat yields exactly one output beat
// (out_valid/out_ready) with the two applied servo widths and the
// playing flag, in input order.
// Path to the output: range select runs in the cycle that takes the input
// beat, then come the reciprocal multiply, the control update with the ring
// buffer access, and folding in the buffer read data on its way into the
// result queue, each ending in a register; out_valid rises once the
// result is in the queue.
// Throughput is one beat per cycle while in_ready is high; the ring buffer
// takes one read or one write per cycle and the map is fully pipelined.
// An 8-deep result queue with a credit count sits at the output: in_ready
// drops only when 8 beats are accepted and not yet delivered, so a
// stalled receiver backs up the input after that many beats, and in_ready
// never depends on out_ready in the same cycle.
// Reset: widths applied 1500, live widths 0, recording mode, pointers 0,
// dead band 1948..2146. The buffer reads as zero until a slot is recorded
// (tracked by the write pointer and a wrap flag), so no clearing pass.
// The user must write configuration only while idle; the block does not check.
module servo_motion_record_replay (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    cmd,
    input  wire logic [smrr_pkg::ADC_W-1:0]    adc_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [smrr_pkg::WIDTH_W-1:0]  servo1_width,
    output logic      [smrr_pkg::WIDTH_W-1:0]  servo2_width,
    output logic                               playing,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [smrr_pkg::CFG_W-1:0]    cfg_data
);
    import smrr_pkg::*;

    typedef enum logic [1:0] {
        APPLY_KEEP = 2'd0,
        APPLY_LIVE = 2'd1,
        APPLY_MEM  = 2'd2
    } apply_t;

    // Config
    logic [ADC_W-1:0] dbl_reg;
    logic [DBH_W-1:0] dbh_reg;

    // Credits
    logic                 in_beat, out_beat;
    logic [OUT_CNT_W-1:0] pending_reg, pending_next;

    // Map stages carry only cmd and valid here
    logic       s1_valid_reg, s2_valid_reg;
    cmd_t       s1_cmd_reg, s2_cmd_reg;
    logic [WIDTH_W-1:0] map_width;

    // Control state
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic               wrapped_reg, wrapped_next;
    logic               play_reg, play_next;
    logic [WIDTH_W-1:0] live1_reg, live1_next;
    logic [WIDTH_W-1:0] live2_reg, live2_next;
    logic [PTR_W-1:0]   rp_step;

    // Ring buffer
    logic [PAIR_W-1:0]  store_mem [STORE_DEPTH];
    logic [PAIR_W-1:0]  rd_data_reg;
    logic               mem_we, mem_re;

    // Apply stage
    logic               w_valid_reg;
    apply_t             w_op_reg, w_op_next;
    logic               w_hit_reg;
    logic [WIDTH_W-1:0] w_live1_reg, w_live2_reg;
    logic               w_play_reg;
    logic [WIDTH_W-1:0] app1_reg, app1_next;
    logic [WIDTH_W-1:0] app2_reg, app2_next;

    result_t            push_data, head_data;

    // -------- configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbl_reg <= ADC_W'(1948);
            dbh_reg <= DBH_W'(2147);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEADBAND_LOW:  dbl_reg <= cfg_data[ADC_W-1:0];
                CFG_DEADBAND_HIGH: dbh_reg <= cfg_data[DBH_W-1:0];
                default:           dbl_reg <= dbl_reg;
            endcase
        end
    end

    // -------- credit count: beats accepted but not delivered
    assign in_ready = pending_reg < OUT_CNT_W'(OUT_DEPTH);
    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg + OUT_CNT_W'(in_beat) - OUT_CNT_W'(out_beat);
    end

    // -------- map pipeline
    smrr_map u_map (
        .clk           (clk),
        .adc_value     (adc_value),
        .deadband_low  (dbl_reg),
        .deadband_high (dbh_reg),
        .width         (map_width)
    );

    // -------- control update (stage 3)
    always_comb
    begin
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        wrapped_next = wrapped_reg;
        play_next    = play_reg;
        live1_next   = live1_reg;
        live2_next   = live2_reg;
        w_op_next    = APPLY_KEEP;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        rp_step      = next_slot(rp_reg);
        if (s2_valid_reg)
        begin
            case (s2_cmd_reg)
                CMD_AXIS1, CMD_AXIS2:
                begin
                    if (s2_cmd_reg == CMD_AXIS1)
                        live1_next = map_width;
                    else
                        live2_next = map_width;
                    w_op_next = play_reg ? APPLY_KEEP : APPLY_LIVE;
                end
                CMD_BUTTON:
                begin
                    if (!play_reg)
                    begin
                        play_next = 1'b1;
                        rp_next   = next_slot(wp_reg);
                    end
                    else
                    begin
                        play_next = 1'b0;
                        w_op_next = APPLY_LIVE;
                    end
                end
                CMD_TICK:
                begin
                    if (!play_reg)
                    begin
                        mem_we  = 1'b1;
                        wp_next = next_slot(wp_reg);
                        if (wp_reg == PTR_W'(STORE_DEPTH - 1))
                            wrapped_next = 1'b1;
                    end
                    else
                    begin
                        rp_next = rp_step;
                        if (rp_step == wp_reg)
                        begin
                            // read pointer caught up with the write pointer, live control takes over at once
                            play_next = 1'b0;
                            w_op_next = APPLY_LIVE;
                        end
                        else
                        begin
                            mem_re    = 1'b1;
                            w_op_next = APPLY_MEM;
                        end
                    end
                end
                default:
                begin
                    w_op_next = APPLY_KEEP;
                end
            endcase
        end
    end

    // One buffer access per cycle, so a read never meets a write to the
    // same slot in the same cycle; no forwarding needed.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[wp_reg] <= {live2_reg, live1_reg};
        if (mem_re)
            rd_data_reg <= store_mem[rp_reg];
    end

    // Apply-stage payload
    always_ff @(posedge clk)
    begin
        w_hit_reg   <= wrapped_reg || (rp_reg < wp_reg);
        w_live1_reg <= live1_next;
        w_live2_reg <= live2_next;
        w_play_reg  <= play_next;
        w_op_reg    <= w_op_next;
    end

    // -------- apply (stage 4)
    always_comb
    begin
        app1_next = app1_reg;
        app2_next = app2_reg;
        if (w_valid_reg)
        begin
            case (w_op_reg)
                APPLY_LIVE:
                begin
                    app1_next = w_live1_reg;
                    app2_next = w_live2_reg;
                end
                APPLY_MEM:
                begin
                    // slot never recorded reads as zero
                    app1_next = w_hit_reg ? rd_data_reg[WIDTH_W-1:0] : '0;
                    app2_next = w_hit_reg ? rd_data_reg[PAIR_W-1:WIDTH_W] : '0;
                end
                default:
                begin
                    app1_next = app1_reg;
                    app2_next = app2_reg;
                end
            endcase
        end
        push_data.servo1_width = app1_next;
        push_data.servo2_width = app2_next;
        push_data.playing      = w_play_reg;
    end

    // -------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            w_valid_reg  <= 1'b0;
            s1_cmd_reg   <= CMD_AXIS1;
            s2_cmd_reg   <= CMD_AXIS1;
            wp_reg       <= '0;
            rp_reg       <= '0;
            wrapped_reg  <= 1'b0;
            play_reg     <= 1'b0;
            live1_reg    <= '0;
            live2_reg    <= '0;
            app1_reg     <= WIDTH_NEUTRAL;
            app2_reg     <= WIDTH_NEUTRAL;
        end
        else
        begin
            pending_reg  <= pending_next;
            s1_valid_reg <= in_beat;
            s2_valid_reg <= s1_valid_reg;
            w_valid_reg  <= s2_valid_reg;
            s1_cmd_reg   <= cmd_t'(cmd);
            s2_cmd_reg   <= s1_cmd_reg;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            wrapped_reg  <= wrapped_next;
            play_reg     <= play_next;
            live1_reg    <= live1_next;
            live2_reg    <= live2_next;
            app1_reg     <= app1_next;
            app2_reg     <= app2_next;
        end
    end

    // -------- result queue
    smrr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (w_valid_reg),
        .push_data (push_data),
        .pop       (out_beat),
        .not_empty (out_valid),
        .head_data (head_data)
    );

    assign servo1_width = head_data.servo1_width;
    assign servo2_width = head_data.servo2_width;
    assign playing      = head_data.playing;

    // -------- checks
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= OUT_CNT_W'(OUT_DEPTH))
        else $error("credit count above queue depth");

    a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("result shown with no beat outstanding");

    a_play_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        play_reg |-> rp_reg != wp_reg)
        else $error("playback running with read pointer at write pointer");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg < PTR_W'(STORE_DEPTH)) && (rp_reg < PTR_W'(STORE_DEPTH)))
        else $error("ring pointer out of range");

endmodule

`default_nettype wire

// File: sim/servo_motion_record_replay_tb.sv
`timescale 1ns / 1ps

module servo_motion_record_replay_tb;

    import smrr_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 6;
    localparam int CYCLE_LIMIT     = 1_000_000;
    // Margin after the last result: catches beats that show up late
    localparam int TAIL_CYCLES     = 12;
    localparam int MAX_REPORTS     = 100;
    localparam int BEATS_PER_PHASE = 190;

    localparam logic [ADC_W-1:0] RESET_DB_LOW  = ADC_W'(1948);
    localparam logic [DBH_W-1:0] RESET_DB_HIGH = DBH_W'(2147);

    // ------------------------------------------------------------------
    // DUT ports. Every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    cmd_t                 cmd       = CMD_AXIS1;
    logic [ADC_W-1:0]     adc_value = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [WIDTH_W-1:0]   servo1_width;
    logic [WIDTH_W-1:0]   servo2_width;
    logic                 playing;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_index = CFG_DEADBAND_LOW;
    logic [CFG_W-1:0]     cfg_data  = '0;

    servo_motion_record_replay DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .adc_value    (adc_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .servo1_width (servo1_width),
        .servo2_width (servo2_width),
        .playing      (playing),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the block: dead band setting, ring buffer, pointers,
    // mode and the live / applied widths.
    // ------------------------------------------------------------------
    logic [ADC_W-1:0]   db_low;
    logic [DBH_W-1:0]   db_high;
    logic [PAIR_W-1:0]  motion_mem [STORE_DEPTH];
    logic [PTR_W-1:0]   rec_ptr;
    logic [PTR_W-1:0]   play_ptr;
    logic               replaying;
    logic [WIDTH_W-1:0] live_one;
    logic [WIDTH_W-1:0] live_two;
    logic [WIDTH_W-1:0] applied_one;
    logic [WIDTH_W-1:0] applied_two;

    // Expected output beats, oldest first
    result_t servo_expect_q[$];

    int unsigned mismatch_count = 0;
    int unsigned beats_sent     = 0;
    int unsigned cycle_count    = 0;
    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_stall_pct = 0;

    task automatic clear_shadow_state();
        db_low      = RESET_DB_LOW;
        db_high     = RESET_DB_HIGH;
        foreach (motion_mem[i])
        begin
            motion_mem[i] = '0;
        end
        rec_ptr     = '0;
        play_ptr    = '0;
        replaying   = 1'b0;
        live_one    = '0;
        live_two    = '0;
        applied_one = WIDTH_NEUTRAL;
        applied_two = WIDTH_NEUTRAL;
    endtask

    function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p);
        int unsigned n;
        n = int'(p) + 1;
        if (n >= STORE_DEPTH)
        begin
            n = 0;
        end
        return PTR_W'(n);
    endfunction

    // ADC count to pulse width in us. The dead band may be empty
    // (low >= high): then the lower mapping wins below db_low and the
    // upper one applies from there on. Both halves clip at 2000 us.
    function automatic logic [WIDTH_W-1:0] width_for_adc(input logic [ADC_W-1:0] adc);
        int unsigned a;
        int unsigned w;
        a = adc;
        if (a >= db_low && a < db_high)
        begin
            w = WIDTH_NEUTRAL;
        end
        else if (a < db_low)
        begin
            w = WIDTH_BASE_LOW + (a * SLOPE) / LOWER_DIV;
        end
        else
        begin
            w = WIDTH_NEUTRAL + ((a - db_high) * SLOPE) / UPPER_DIV;
        end
        if (w > WIDTH_MAX)
        begin
            w = WIDTH_MAX;
        end
        return WIDTH_W'(w);
    endfunction

    // Advance the shadow state by one accepted beat and return the output
    // beat it must produce.
    function automatic result_t predict_servo_beat(input cmd_t op,
                                                   input logic [ADC_W-1:0] adc);
        result_t r;
        case (op)
            CMD_AXIS1, CMD_AXIS2:
            begin
                if (op == CMD_AXIS1)
                begin
                    live_one = width_for_adc(adc);
                end
                else
                begin
                    live_two = width_for_adc(adc);
                end
                // while replaying only the live copy moves
                if (!replaying)
                begin
                    applied_one = live_one;
                    applied_two = live_two;
                end
            end
            CMD_BUTTON:
            begin
                if (!replaying)
                begin
                    replaying = 1'b1;
                    play_ptr  = ring_advance(rec_ptr);
                end
                else
                begin
                    replaying   = 1'b0;
                    applied_one = live_one;
                    applied_two = live_two;
                end
            end
            default:
            begin
                if (!replaying)
                begin
                    motion_mem[rec_ptr] = {live_two, live_one};
                    rec_ptr = ring_advance(rec_ptr);
                end
                else
                begin
                    {applied_two, applied_one} = motion_mem[play_ptr];
                    play_ptr = ring_advance(play_ptr);
                    // caught up with the recording: hand back to the stick
                    if (play_ptr == rec_ptr)
                    begin
                        replaying   = 1'b0;
                        applied_one = live_one;
                        applied_two = live_two;
                    end
                end
            end
        endcase
        r.servo1_width = applied_one;
        r.servo2_width = applied_two;
        r.playing      = replaying;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting. Printing stops after MAX_REPORTS lines so a
    // badly broken build still leaves a readable log; counting does not.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls on out_ready, and every beat taken is
    // compared with the oldest expectation, field by field. Handshake is
    // sampled at the edge, i.e. pre-edge values.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (servo_expect_q.size() == 0)
            begin
                report_mismatch($sformatf("output beat with nothing expected (%0d %0d %0d)",
                                          servo1_width, servo2_width, playing));
            end
            else
            begin
                want = servo_expect_q.pop_front();
                if (servo1_width !== want.servo1_width)
                begin
                    report_mismatch($sformatf("servo1_width got %0d want %0d",
                                              servo1_width, want.servo1_width));
                end
                if (servo2_width !== want.servo2_width)
                begin
                    report_mismatch($sformatf("servo2_width got %0d want %0d",
                                              servo2_width, want.servo2_width));
                end
                if (playing !== want.playing)
                begin
                    report_mismatch($sformatf("playing got %0b want %0b",
                                              playing, want.playing));
                end
            end
        end
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d beats still expected",
                     cycle_count, servo_expect_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side. Every task returns in the time step of a rising edge.
    // send_beat leaves in_valid high after its beat is taken, so the
    // caller must drive it again (next beat, or low) before time moves.
    // ------------------------------------------------------------------
    task automatic send_beat(input cmd_t op, input logic [ADC_W-1:0] sample);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= op;
        adc_value <= sample;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        servo_expect_q.push_back(predict_servo_beat(op, sample));
        beats_sent++;
    endtask

    // Drop valid and hold off until every expected beat has come out.
    // Always crosses at least one edge, so a following register write
    // never lands in the same step as the previous one.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (servo_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Both registers, written back to back while the block is idle
    task automatic set_deadband(input logic [ADC_W-1:0] lo, input logic [DBH_W-1:0] hi);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEADBAND_LOW;
        cfg_data  <= CFG_W'(lo);
        @(posedge clk);
        cfg_index <= CFG_DEADBAND_HIGH;
        cfg_data  <= CFG_W'(hi);
        @(posedge clk);
        cfg_we    <= 1'b0;
        db_low  = lo;
        db_high = hi;
    endtask

    task automatic set_idling(input int unsigned idle_pct, input int unsigned stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
    endtask

    // ADC value biased toward the band edges and the rails
    function automatic logic [ADC_W-1:0] pick_adc();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return ADC_W'(db_low);
            3:       return ADC_W'(db_low - 1'b1);
            4:       return ADC_W'(db_high);
            5:       return ADC_W'(db_high - 1'b1);
            default: return ADC_W'($urandom_range(4095));
        endcase
    endfunction

    // adc_value is don't-care on button and tick, keep it moving anyway
    function automatic logic [ADC_W-1:0] junk_adc();
        return ADC_W'($urandom_range(4095));
    endfunction

    task automatic send_sample();
        send_beat(($urandom_range(1) != 0) ? CMD_AXIS2 : CMD_AXIS1, pick_adc());
    endtask

    task automatic send_tick();
        send_beat(CMD_TICK, junk_adc());
    endtask

    task automatic press_button();
        send_beat(CMD_BUTTON, junk_adc());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset: applied widths at neutral, live widths zero,
    // and playback of never-recorded slots gives zero widths.
    task automatic test_reset_state();
        send_tick();                        // records the zero live pair
        press_button();                     // play from the slot after the write pointer
        send_tick();                        // empty slot -> 0 / 0
        send_beat(CMD_AXIS1, '1);           // live only while replaying
        press_button();                     // back to live: 2000 / 0
    endtask

    // Default band, both axes, across the rails and each edge of the band
    task automatic test_default_map();
        send_beat(CMD_AXIS1, ADC_W'(0));
        send_beat(CMD_AXIS2, ADC_W'(1947));
        send_beat(CMD_AXIS1, ADC_W'(1948));
        send_beat(CMD_AXIS2, ADC_W'(2146));
        send_beat(CMD_AXIS1, ADC_W'(2147));
        send_beat(CMD_AXIS2, ADC_W'(4095));
        send_tick();
        press_button();
        send_tick();
        press_button();
    endtask

    // Register extremes: empty band at zero, band squeezed to the top
    // (lower half clips at 2000), empty inverted band, band over all.
    task automatic test_deadband_extremes();
        set_deadband(ADC_W'(0), DBH_W'(0));
        send_beat(CMD_AXIS1, ADC_W'(0));
        send_beat(CMD_AXIS2, ADC_W'(4095));     // upper half clips
        set_deadband(ADC_W'(4095), DBH_W'(4096));
        send_beat(CMD_AXIS1, ADC_W'(4094));     // lower half clips
        send_beat(CMD_AXIS2, ADC_W'(4095));
        set_deadband(ADC_W'(2000), DBH_W'(1000));
        send_beat(CMD_AXIS1, ADC_W'(1999));
        send_beat(CMD_AXIS2, ADC_W'(2000));
        set_deadband(ADC_W'(0), DBH_W'(4096));
        send_beat(CMD_AXIS1, ADC_W'(0));
        send_beat(CMD_AXIS2, ADC_W'(4095));
        set_deadband(RESET_DB_LOW, RESET_DB_HIGH);
    endtask

    // Record / replay sessions with random content, plus some noise
    // beats. Now and then the sender holds off until the output drains.
    task automatic run_sessions(input int unsigned beat_budget);
        int unsigned stop_at;
        int unsigned n;
        stop_at = beats_sent + beat_budget;
        while (beats_sent < stop_at)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_beat(cmd_t'($urandom_range(3)), pick_adc());
            end
            else
            begin
                if (replaying)
                begin
                    press_button();
                end
                n = $urandom_range(30, 3);
                repeat (n)
                begin
                    if ($urandom_range(99) < 45)
                    begin
                        send_sample();
                    end
                    else
                    begin
                        send_tick();
                    end
                end
                press_button();
                n = $urandom_range(25, 0);
                repeat (n)
                begin
                    if ($urandom_range(99) < 20)
                    begin
                        send_sample();
                    end
                    else
                    begin
                        send_tick();
                    end
                end
                if ($urandom_range(3) != 0)
                begin
                    press_button();
                end
            end
            if ($urandom_range(24) == 0)
            begin
                wait_for_results();
            end
        end
    endtask

    // Eight phases: each of the four idling patterns twice, each phase
    // with its own band setting (fixed extremes and random ones).
    task automatic test_random_traffic();
        int               k;
        logic [ADC_W-1:0] lo;
        logic [DBH_W-1:0] hi;
        for (k = 0; k < 8; k++)
        begin
            case (k)
                0:
                begin
                    lo = RESET_DB_LOW;
                    hi = RESET_DB_HIGH;
                end
                1:
                begin
                    lo = '0;
                    hi = '0;
                end
                2:
                begin
                    lo = ADC_W'(4095);
                    hi = DBH_W'(4096);
                end
                4:
                begin
                    lo = ADC_W'(4095);
                    hi = '0;
                end
                5:
                begin
                    lo = '0;
                    hi = DBH_W'(4096);
                end
                default:
                begin
                    lo = ADC_W'($urandom_range(4095));
                    hi = DBH_W'($urandom_range(4096));
                end
            endcase
            set_deadband(lo, hi);
            case (k % 4)
                0:       set_idling(0, 0);
                1:       set_idling(65, 0);
                2:       set_idling(0, 65);
                default: set_idling(38, 38);
            endcase
            run_sessions(BEATS_PER_PHASE);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        clear_shadow_state();
        repeat (RESET_CYCLES)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_default_map();
        test_deadband_extremes();
        test_random_traffic();

        wait_for_results();
        set_idling(0, 0);
        repeat (TAIL_CYCLES)
        begin
            @(posedge clk);
        end
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
sv/smrr_pkg.sv
sv/smrr_map.sv
sv/smrr_out_fifo.sv
sv/servo_motion_record_replay.sv
sim/servo_motion_record_replay_tb.sv
